// ===== sv/free_range_allocator_assert.svh =====
// Assertion macros shared by the free range allocator RTL.
// Depends on nothing; included inside module bodies.
`ifndef FREE_RANGE_ALLOCATOR_ASSERT_SVH
`define FREE_RANGE_ALLOCATOR_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define FRA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define FRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== sv/fra_pkg.sv =====
// Package for the free range allocator: constants, opcodes, status codes.
// No dependencies.
package fra_pkg;
    localparam int MAX_RANGES_DEF = 16;
    localparam int ADDR_BITS_DEF  = 40;
    localparam int COUNT_BITS     = 5;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_PROBE = 2'd2,
        OP_BAD   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_INVALID = 2'd2,
        ST_FULL    = 2'd3
    } status_t;
endpackage

// ===== sv/free_range_allocator.sv =====
// Free range allocator: sorted free-range table searched, shifted and merged
// by one shared compare/add unit. Uses fra_pkg, free_range_allocator_assert.svh.
// One request at a time, one table entry per cycle. A waiting result does not
// block the input. Reset and a pool_size write reload the table as one range
// [0, pool_size); a pool_size write of zero leaves the table empty.
module free_range_allocator #(
    parameter int MAX_RANGES = fra_pkg::MAX_RANGES_DEF,
    parameter int ADDR_BITS  = fra_pkg::ADDR_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [ADDR_BITS-1:0] cfg_wdata,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // opcode
    input  logic [1:0] s_axis_tuser,
    // req_size, free_offset, best_fit from low bit up, zero padded
    input  logic [((2*ADDR_BITS+1+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // status [1:0], grant_offset, grant_length, free sum, largest_free,
    // range_count (5) from low bit up, zero padded
    output logic [((4*ADDR_BITS+7+7)/8)*8-1:0] m_axis_tdata
);
    import fra_pkg::*;
`include "free_range_allocator_assert.svh"

    localparam int OW = ((4*ADDR_BITS+7+7)/8)*8;
    localparam int IB = $clog2(MAX_RANGES);
    localparam int CB = $clog2(MAX_RANGES+1);
    localparam logic [ADDR_BITS-1:0] AMAX = {ADDR_BITS{1'b1}};
    localparam logic [CB-1:0] MAXC = CB'(MAX_RANGES);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SEARCH = 8'b0000_0010,
        S_DECIDE = 8'b0000_0100,
        S_SHIFT  = 8'b0000_1000,
        S_REMOVE = 8'b0001_0000,
        S_MERGE  = 8'b0010_0000,
        S_STATS  = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [ADDR_BITS-1:0] start_reg [MAX_RANGES];
    logic [ADDR_BITS-1:0] len_reg   [MAX_RANGES];
    logic [CB-1:0] count_reg;
    logic [ADDR_BITS-1:0] pool_reg;

    opcode_t op_reg;
    logic [ADDR_BITS-1:0] size_reg, off_reg;
    logic best_reg;
    logic [CB-1:0] idx_reg;        // scan pointer
    logic [CB-1:0] pick_reg;       // found entry / insert position / merge return
    logic found_reg, exact_reg;
    logic [1:0] status_reg;
    logic [ADDR_BITS-1:0] goff_reg, glen_reg, total_reg, largest_reg;
    logic [OW-1:0] out_reg;
    logic out_valid_reg;

    // Shared unit: compares and adds on entry idx and its neighbor
    logic [IB-1:0] ia, ib, pi;
    logic [ADDR_BITS-1:0] a_start, a_len, b_start, b_len, pick_start, pick_len;
    logic [ADDR_BITS:0] sum_w, end_w;
    logic touch;
    assign ia = idx_reg[IB-1:0];
    assign ib = IB'(idx_reg + CB'(1));
    assign pi = pick_reg[IB-1:0];
    assign a_start = start_reg[ia];
    assign a_len   = len_reg[ia];
    assign b_start = start_reg[ib];
    assign b_len   = len_reg[ib];
    assign pick_start = start_reg[pi];
    assign pick_len   = len_reg[pi];
    assign end_w = {1'b0, a_start} + {1'b0, a_len};
    assign sum_w = (state_reg == S_MERGE) ? {1'b0, a_len} + {1'b0, b_len}
                                          : {1'b0, total_reg} + {1'b0, a_len};
    assign touch = (end_w[ADDR_BITS-1:0] == b_start) && !end_w[ADDR_BITS];

    logic in_acc, out_free, out_stall, alloc_ok;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_reg;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign out_stall = out_valid_reg && !m_axis_tready;
    assign alloc_ok = (size_reg != '0) && (size_reg <= pool_reg) && found_reg;

    logic scan_end, merge_end;
    assign scan_end  = idx_reg >= count_reg;
    assign merge_end = (idx_reg + CB'(1)) >= count_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_acc) state_next = S_SEARCH;
            S_SEARCH:
            begin
                priority if (op_reg == OP_BAD) state_next = S_STATS;
                else if (scan_end) state_next = S_DECIDE;
                else if (op_reg != OP_ALLOC || !best_reg)
                begin
                    if (op_reg == OP_FREE)
                    begin
                        if (a_start >= off_reg) state_next = S_DECIDE;
                    end
                    else if (a_len >= size_reg) state_next = S_DECIDE;
                end
                else state_next = S_SEARCH;
            end
            S_DECIDE:
            begin
                state_next = S_STATS;
                if (op_reg == OP_ALLOC)
                begin
                    if (alloc_ok && !(pick_len > size_reg)) state_next = S_REMOVE;
                end
                else if (op_reg == OP_FREE && size_reg != '0)
                begin
                    if (exact_reg) state_next = S_MERGE;
                    else if (count_reg < MAXC) state_next = S_SHIFT;
                end
            end
            S_SHIFT:  if (idx_reg == pick_reg) state_next = S_MERGE;
            S_REMOVE:
                if (merge_end) state_next = (op_reg == OP_FREE) ? S_MERGE : S_STATS;
            S_MERGE:
            begin
                if (merge_end) state_next = S_STATS;
                else if (touch) state_next = S_REMOVE;
            end
            S_STATS:  if (scan_end) state_next = S_OUT;
            S_OUT:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CB'(1);
            pool_reg <= AMAX;
            for (int i = 0; i < MAX_RANGES; i++)
            begin
                start_reg[i] <= '0;
                len_reg[i] <= (i == 0) ? AMAX : '0;
            end
            out_valid_reg <= 1'b0;
            out_reg <= '0;
            idx_reg <= '0;
            pick_reg <= '0;
            op_reg <= OP_ALLOC;
            size_reg <= '0;
            off_reg <= '0;
            best_reg <= 1'b0;
            found_reg <= 1'b0;
            exact_reg <= 1'b0;
            status_reg <= ST_OK;
            goff_reg <= '0;
            glen_reg <= '0;
            total_reg <= '0;
            largest_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // hold the result until the sink takes it
            if (state_reg == S_OUT && out_free)
            begin
                out_reg <= OW'({COUNT_BITS'(count_reg), largest_reg, total_reg, glen_reg,
                                goff_reg, status_reg});
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready) out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                pool_reg <= cfg_wdata;
                start_reg[0] <= '0;
                len_reg[0] <= cfg_wdata;
                count_reg <= (cfg_wdata != '0) ? CB'(1) : '0;
            end
            else
            begin
                unique case (state_reg)
                    S_IDLE:
                    begin
                        if (in_acc)
                        begin
                            op_reg <= opcode_t'(s_axis_tuser);
                            size_reg <= s_axis_tdata[0 +: ADDR_BITS];
                            off_reg <= s_axis_tdata[ADDR_BITS +: ADDR_BITS];
                            best_reg <= s_axis_tdata[2*ADDR_BITS];
                            idx_reg <= '0;
                            found_reg <= 1'b0;
                            exact_reg <= 1'b0;
                            pick_reg <= count_reg;
                            goff_reg <= '0;
                            glen_reg <= '0;
                        end
                    end
                    S_SEARCH:
                    begin
                        if (op_reg == OP_BAD)
                        begin
                            status_reg <= ST_INVALID;
                            idx_reg <= '0;
                            total_reg <= '0;
                            largest_reg <= '0;
                        end
                        else if (!scan_end)
                        begin
                            if (op_reg == OP_FREE)
                            begin
                                if (a_start >= off_reg)
                                begin
                                    pick_reg <= idx_reg;
                                    exact_reg <= (a_start == off_reg);
                                end
                            end
                            else if (a_len >= size_reg)
                            begin
                                if (!found_reg || a_len < pick_len)
                                    pick_reg <= idx_reg;
                                found_reg <= 1'b1;
                            end
                            idx_reg <= idx_reg + CB'(1);
                        end
                    end
                    S_DECIDE:
                    begin
                        total_reg <= '0;
                        largest_reg <= '0;
                        unique case (op_reg)
                            OP_ALLOC:
                            begin
                                if (size_reg == '0 || size_reg > pool_reg)
                                begin
                                    status_reg <= ST_INVALID;
                                    idx_reg <= '0;
                                end
                                else if (!found_reg)
                                begin
                                    status_reg <= ST_NOFIT;
                                    idx_reg <= '0;
                                end
                                else
                                begin
                                    status_reg <= ST_OK;
                                    goff_reg <= pick_start;
                                    glen_reg <= size_reg;
                                    if (pick_len > size_reg)
                                    begin
                                        start_reg[pi] <= pick_start + size_reg;
                                        len_reg[pi] <= pick_len - size_reg;
                                        idx_reg <= '0;
                                    end
                                    else idx_reg <= pick_reg;
                                end
                            end
                            OP_FREE:
                            begin
                                idx_reg <= (size_reg != '0 && !exact_reg && count_reg < MAXC)
                                           ? count_reg : '0;
                                if (size_reg == '0) status_reg <= ST_INVALID;
                                else if (exact_reg)
                                begin
                                    status_reg <= ST_OK;
                                    len_reg[pi] <= size_reg;
                                end
                                else if (count_reg >= MAXC) status_reg <= ST_FULL;
                                else
                                begin
                                    status_reg <= ST_OK;
                                    count_reg <= count_reg + CB'(1);
                                end
                            end
                            OP_PROBE:
                            begin
                                idx_reg <= '0;
                                status_reg <= found_reg ? ST_OK : ST_NOFIT;
                            end
                            default:
                            begin
                                idx_reg <= '0;
                                status_reg <= ST_INVALID;
                            end
                        endcase
                    end
                    S_SHIFT:
                    begin
                        // move one entry up per cycle until the hole reaches pick
                        if (idx_reg == pick_reg)
                        begin
                            start_reg[ia] <= off_reg;
                            len_reg[ia] <= size_reg;
                            idx_reg <= '0;
                        end
                        else
                        begin
                            start_reg[ia] <= start_reg[IB'(idx_reg - CB'(1))];
                            len_reg[ia] <= len_reg[IB'(idx_reg - CB'(1))];
                            idx_reg <= idx_reg - CB'(1);
                        end
                    end
                    S_REMOVE:
                    begin
                        if (merge_end)
                        begin
                            count_reg <= count_reg - CB'(1);
                            // a merge resumes at the entry that absorbed the neighbor
                            idx_reg <= (op_reg == OP_FREE) ? pick_reg : '0;
                        end
                        else
                        begin
                            start_reg[ia] <= b_start;
                            len_reg[ia] <= b_len;
                            idx_reg <= idx_reg + CB'(1);
                        end
                    end
                    S_MERGE:
                    begin
                        if (merge_end) idx_reg <= '0;
                        else if (touch)
                        begin
                            // absorb the neighbor, then close the gap it leaves
                            len_reg[ia] <= sum_w[ADDR_BITS] ? AMAX : sum_w[ADDR_BITS-1:0];
                            pick_reg <= idx_reg;
                            idx_reg <= idx_reg + CB'(1);
                        end
                        else idx_reg <= idx_reg + CB'(1);
                    end
                    S_STATS:
                    begin
                        if (!scan_end)
                        begin
                            total_reg <= sum_w[ADDR_BITS] ? AMAX : sum_w[ADDR_BITS-1:0];
                            if (a_len > largest_reg) largest_reg <= a_len;
                            idx_reg <= idx_reg + CB'(1);
                        end
                    end
                    S_OUT: ;
                    default: ;
                endcase
            end
        end
    end

    `FRA_ASSERT_IMP(a_state_onehot, clk, rst_n, 1'b1, $onehot(state_reg), "state not one-hot")
    `FRA_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= MAXC, "range count too high")
    `FRA_ASSERT_IMP(a_ready_idle, clk, rst_n, s_axis_tready, state_reg == S_IDLE, "ready off idle")
    `FRA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid_reg && $stable(out_reg),
                     "result changed while stalled")
endmodule

// ===== bench/free_range_allocator_tb.sv =====
// Self-checking bench for free_range_allocator: directed and random allocate,
// free and probe transactions checked against an in-bench table predictor.
// Depends on fra_pkg and the free_range_allocator RTL.
`timescale 1ns / 100ps

module free_range_allocator_tb;
    import fra_pkg::*;

    localparam int RANGES = MAX_RANGES_DEF;
    localparam int AW = ADDR_BITS_DEF;
    localparam bit [63:0] ADDR_MASK = (64'd1 << AW) - 64'd1;
    localparam int IN_W = ((2*AW+1+7)/8)*8;
    localparam int OUT_W = ((4*AW+7+7)/8)*8;
    localparam int DRAIN_CYCLES = 3*RANGES + 20;

    typedef struct packed {
        status_t status;
        logic [AW-1:0] grant_offset;
        logic [AW-1:0] grant_length;
        logic [AW-1:0] free_sum;
        logic [AW-1:0] largest_free;
        logic [COUNT_BITS-1:0] range_count;
    } answer_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [AW-1:0] cfg_wdata;
    logic s_axis_tvalid;
    logic s_axis_tready;
    // opcode
    logic [1:0] s_axis_tuser;
    // req_size, free_offset, best_fit, zero padded
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    // status [1:0], grant_offset, grant_length, free sum, largest_free, range_count
    logic [OUT_W-1:0] m_axis_tdata;

    free_range_allocator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predicted free table
    bit [63:0] pool_bytes;
    bit [63:0] free_start [RANGES];
    bit [63:0] free_len [RANGES];
    int unsigned free_cnt;

    answer_t pending_answers [$];
    int error_count;
    int sent_count;
    int checked_count;
    int full_hits;
    int last_status;
    bit [63:0] last_grant;

    // blocks granted in the current random phase, for well-formed frees
    bit [63:0] held_off [$];
    bit [63:0] held_len [$];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("%0t timeout", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(80, 20);
    endfunction

    function automatic bit [63:0] sat_sum(bit [63:0] a, bit [63:0] b);
        bit [63:0] s;
        s = a + b;
        return (s > ADDR_MASK) ? ADDR_MASK : s;
    endfunction

    task automatic load_table();
        for (int i = 0; i < RANGES; i++)
        begin
            free_start[i] = 0;
            free_len[i] = 0;
        end
        free_cnt = 0;
        if (pool_bytes != 0)
        begin
            free_len[0] = pool_bytes;
            free_cnt = 1;
        end
    endtask

    task automatic drop_entry(int unsigned idx);
        for (int unsigned i = idx; i + 1 < free_cnt; i++)
        begin
            free_start[i] = free_start[i+1];
            free_len[i] = free_len[i+1];
        end
        free_cnt--;
        free_start[free_cnt] = 0;
        free_len[free_cnt] = 0;
    endtask

    task automatic merge_neighbors();
        int unsigned i;
        i = 0;
        while (i + 1 < free_cnt)
        begin
            if (free_start[i] + free_len[i] == free_start[i+1])
            begin
                free_len[i] = sat_sum(free_len[i], free_len[i+1]);
                drop_entry(i + 1);
            end
            else
                i++;
        end
    endtask

    function automatic int unsigned fit_index(bit [63:0] size, bit best);
        int unsigned pick;
        pick = free_cnt;
        for (int unsigned i = 0; i < free_cnt; i++)
        begin
            if (free_len[i] >= size)
            begin
                if (!best) return i;
                if (pick == free_cnt || free_len[i] < free_len[pick]) pick = i;
            end
        end
        return pick;
    endfunction

    task automatic release_range(input bit [63:0] off, input bit [63:0] len,
                                 output status_t st);
        int unsigned pos;
        st = ST_OK;
        if (len == 0)
        begin
            st = ST_INVALID;
            return;
        end
        pos = free_cnt;
        for (int unsigned i = 0; i < free_cnt; i++)
        begin
            if (free_start[i] == off)
            begin
                free_len[i] = len;
                merge_neighbors();
                return;
            end
            if (free_start[i] > off)
            begin
                pos = i;
                break;
            end
        end
        if (free_cnt >= RANGES)
        begin
            st = ST_FULL;
            return;
        end
        for (int unsigned i = free_cnt; i > pos; i--)
        begin
            free_start[i] = free_start[i-1];
            free_len[i] = free_len[i-1];
        end
        free_start[pos] = off;
        free_len[pos] = len;
        free_cnt++;
        merge_neighbors();
    endtask

    task automatic predict_answer(input opcode_t op, input bit [63:0] size,
                                  input bit [63:0] off, input bit best,
                                  output answer_t ans);
        int unsigned k;
        bit [63:0] total;
        bit [63:0] largest;
        status_t st;
        st = ST_OK;
        ans = '0;
        case (op)
            OP_ALLOC:
            begin
                if (size == 0 || size > pool_bytes)
                    st = ST_INVALID;
                else
                begin
                    k = fit_index(size, best);
                    if (k >= free_cnt)
                        st = ST_NOFIT;
                    else
                    begin
                        ans.grant_offset = free_start[k][AW-1:0];
                        ans.grant_length = size[AW-1:0];
                        if (free_len[k] > size)
                        begin
                            free_start[k] = (free_start[k] + size) & ADDR_MASK;
                            free_len[k] -= size;
                        end
                        else
                            drop_entry(k);
                    end
                end
            end
            OP_FREE: release_range(off, size, st);
            OP_PROBE: st = (fit_index(size, 1'b0) < free_cnt) ? ST_OK : ST_NOFIT;
            default: st = ST_INVALID;
        endcase
        total = 0;
        largest = 0;
        for (int unsigned i = 0; i < free_cnt; i++)
        begin
            total = sat_sum(total, free_len[i]);
            if (free_len[i] > largest) largest = free_len[i];
        end
        ans.status = st;
        ans.free_sum = total[AW-1:0];
        ans.largest_free = largest[AW-1:0];
        ans.range_count = free_cnt[COUNT_BITS-1:0];
    endtask

    // one transaction on the request side; the prediction is made on acceptance
    task automatic send_request(opcode_t op, bit [63:0] size, bit [63:0] off, bit best);
        answer_t ans;
        int gap;
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = op;
        s_axis_tdata = '0;
        s_axis_tdata[0 +: AW] = size[AW-1:0];
        s_axis_tdata[AW +: AW] = off[AW-1:0];
        s_axis_tdata[2*AW] = best;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_answer(op, size & ADDR_MASK, off & ADDR_MASK, best, ans);
        pending_answers = {pending_answers, ans};
        sent_count++;
        last_status = ans.status;
        last_grant = ans.grant_offset;
        if (ans.status == ST_FULL) full_hits++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        // drop the request line so the last transaction is not taken twice
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_answers.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // table must be idle here
    task automatic set_pool(bit [63:0] bytes);
        wait_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        cfg_we = 1'b1;
        cfg_wdata = bytes[AW-1:0];
        pool_bytes = bytes & ADDR_MASK;
        load_table();
        held_off.delete();
        held_len.delete();
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // result side: random back-pressure
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        answer_t want;
        answer_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = answer_t'({m_axis_tdata[1:0], m_axis_tdata[2 +: AW],
                             m_axis_tdata[2+AW +: AW], m_axis_tdata[2+2*AW +: AW],
                             m_axis_tdata[2+3*AW +: AW],
                             m_axis_tdata[2+4*AW +: COUNT_BITS]});
            if (pending_answers.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, got);
                error_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                checked_count++;
                if (got.status !== want.status)
                    $display("%0t status exp %0d got %0d", $time, want.status, got.status);
                if (got.grant_offset !== want.grant_offset)
                    $display("%0t grant_offset exp %h got %h", $time,
                             want.grant_offset, got.grant_offset);
                if (got.grant_length !== want.grant_length)
                    $display("%0t grant_length exp %h got %h", $time,
                             want.grant_length, got.grant_length);
                if (got.free_sum !== want.free_sum)
                    $display("%0t free sum exp %h got %h", $time,
                             want.free_sum, got.free_sum);
                if (got.largest_free !== want.largest_free)
                    $display("%0t largest_free exp %h got %h", $time,
                             want.largest_free, got.largest_free);
                if (got.range_count !== want.range_count)
                    $display("%0t range_count exp %0d got %0d", $time,
                             want.range_count, got.range_count);
                if (got !== want) error_count++;
            end
        end
    end

    task automatic test_reset_pool();
        send_request(OP_ALLOC, 0, 0, 1'b0);
        send_request(OP_ALLOC, 1, 0, 1'b0);
        send_request(OP_PROBE, ADDR_MASK - 1, 0, 1'b0);
        send_request(OP_PROBE, ADDR_MASK, 0, 1'b0);
        send_request(OP_PROBE, 0, 0, 1'b0);
        send_request(OP_BAD, ADDR_MASK, ADDR_MASK, 1'b1);
        send_request(OP_FREE, 0, 0, 1'b0);
        send_request(OP_FREE, 1, 0, 1'b0);
        send_request(OP_ALLOC, ADDR_MASK, 0, 1'b1);
        send_request(OP_PROBE, 0, 0, 1'b1);
        send_request(OP_ALLOC, 1, 0, 1'b0);
        send_request(OP_FREE, 1, ADDR_MASK, 1'b0);
        send_request(OP_FREE, ADDR_MASK, 0, 1'b0);
    endtask

    task automatic test_full_table_and_fit();
        set_pool(0);
        send_request(OP_PROBE, 0, 0, 1'b0);
        // disjoint ranges with varied lengths, one past the table size
        for (int i = 0; i <= RANGES; i++)
            send_request(OP_FREE, 64'(1 + (i * 7) % 5), 64'(16 * i), 1'b0);
        send_request(OP_FREE, 9, 16 * 3, 1'b0);
        send_request(OP_ALLOC, 2, 0, 1'b1);
        send_request(OP_ALLOC, 2, 0, 1'b0);
        send_request(OP_ALLOC, 6, 0, 1'b1);
        send_request(OP_FREE, 8, 2, 1'b0);
    endtask

    task automatic test_length_saturation();
        set_pool(0);
        send_request(OP_FREE, 64'd1 << (AW - 1), 0, 1'b0);
        send_request(OP_FREE, (64'd1 << (AW - 1)) + 100, 64'd1 << (AW - 1), 1'b0);
        send_request(OP_ALLOC, ADDR_MASK, 0, 1'b0);
        set_pool(1);
        send_request(OP_ALLOC, 2, 0, 1'b0);
        send_request(OP_ALLOC, 1, 0, 1'b1);
        send_request(OP_FREE, ADDR_MASK, ADDR_MASK, 1'b1);
    endtask

    task automatic test_random_traffic(bit [63:0] bytes, int count);
        bit [63:0] size;
        bit [63:0] span;
        int r;
        int k;
        set_pool(bytes);
        span = (bytes > 64) ? bytes / 8 : ((bytes == 0) ? 1 : bytes);
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2) wait_drained();
            r = $urandom_range(99);
            if (r < 45)
            begin
                size = 1 + ({$urandom, $urandom} % span);
                send_request(OP_ALLOC, size, {$urandom, $urandom}, 1'($urandom_range(1)));
                if (last_status == ST_OK)
                begin
                    held_off = {held_off, last_grant};
                    held_len = {held_len, size};
                end
            end
            else if (r < 78 && held_off.size() != 0)
            begin
                k = $urandom_range(held_off.size() - 1);
                size = held_len[k];
                // sometimes give back only the front of the block
                if ($urandom_range(3) == 0 && size > 1) size = 1 + size / 2;
                send_request(OP_FREE, size, held_off[k], 1'($urandom_range(1)));
                held_off.delete(k);
                held_len.delete(k);
            end
            else if (r < 88)
                send_request(OP_PROBE, {$urandom, $urandom} % (span * 2 + 1), 0, 1'b0);
            else
            begin
                case ($urandom_range(3))
                    0: send_request(OP_BAD, {$urandom, $urandom}, {$urandom, $urandom},
                                    1'($urandom_range(1)));
                    1: send_request(OP_ALLOC, {$urandom, $urandom}, {$urandom, $urandom},
                                    1'($urandom_range(1)));
                    2: send_request(OP_FREE, {$urandom, $urandom}, {$urandom, $urandom},
                                    1'($urandom_range(1)));
                    default: send_request(OP_FREE, 0, 64'($urandom_range(63)), 1'b0);
                endcase
            end
        end
    endtask

    initial
    begin
        error_count = 0;
        sent_count = 0;
        checked_count = 0;
        full_hits = 0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = '0;
        s_axis_tdata = '0;
        pool_bytes = ADDR_MASK;
        load_table();
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_pool();
        test_full_table_and_fit();
        test_length_saturation();
        test_random_traffic(1000, 170);
        test_random_traffic(1, 60);
        test_random_traffic(4096, 170);
        test_random_traffic(ADDR_MASK, 170);
        test_random_traffic(64'($urandom_range(20000, 100)), 170);
        test_random_traffic({$urandom, $urandom} & ADDR_MASK, 60);

        wait_drained();
        $display("%0d requests sent, %0d results checked, %0d table-full rejects",
                 sent_count, checked_count, full_hits);
        $display("covered allocate/free/probe, both fit policies, six pool sizes");
        if (error_count == 0 && pending_answers.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+sv
sv/fra_pkg.sv
sv/free_range_allocator.sv
bench/free_range_allocator_tb.sv
